>>> sv/lsps_pkg.sv
// Shared types and constants for the line sensor PID steering block.
package lsps_pkg;

   localparam int POS_W   = 3;
   localparam int ERR_W   = 4;
   localparam int DER_W   = 5;
   localparam int GAIN_W  = 12;
   localparam int DUTY_W  = 16;
   localparam int LIM_W   = 13;
   localparam int DRIVE_W = 14;
   localparam int PAT_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_DUTY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 3'd5;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_P_RST      = 12'd700;
   localparam logic [GAIN_W-1:0] GAIN_D_RST      = 12'd300;
   localparam logic [GAIN_W-1:0] GAIN_I_RST      = 12'd20;
   localparam logic [POS_W-1:0]  TARGET_RST      = 3'd3;
   localparam logic [DUTY_W-1:0] BASE_DUTY_RST   = 16'd12000;
   localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 13'd3999;

   localparam logic [POS_W-1:0] POS_CENTER = 3'd3;
   localparam logic [POS_W-1:0] POS_LEFT_EDGE  = 3'd0;
   localparam logic [POS_W-1:0] POS_RIGHT_EDGE = 3'd6;

   // sensor patterns for each position
   localparam logic [PAT_W-1:0] PAT_POS0 = 8'h78;
   localparam logic [PAT_W-1:0] PAT_POS1 = 8'h70;
   localparam logic [PAT_W-1:0] PAT_POS2 = 8'h60;
   localparam logic [PAT_W-1:0] PAT_POS3 = 8'h44;
   localparam logic [PAT_W-1:0] PAT_POS4 = 8'h0C;
   localparam logic [PAT_W-1:0] PAT_POS5 = 8'h1C;
   localparam logic [PAT_W-1:0] PAT_POS6 = 8'h3C;

   typedef struct packed {
      logic             known;
      logic [POS_W-1:0] pos;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_d;
      logic [GAIN_W-1:0] gain_i;
      logic [POS_W-1:0]  target;
      logic [DUTY_W-1:0] base_duty;
      logic [LIM_W-1:0]  drive_limit;
   } cfg_type;

endpackage

>>> sv/lsps_front.sv
// Front end: decodes the sensor byte and holds it in a two-entry queue.
module lsps_front import lsps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PAT_W-1:0] req_sensor_pattern,
   output logic             q_valid,
   output item_type         q_item,
   input  logic             q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   dec;
   logic       push;

   always_comb begin
      dec.known = 1'b1;
      dec.pos   = POS_CENTER;
      case (req_sensor_pattern)
         PAT_POS0: dec.pos = 3'd0;
         PAT_POS1: dec.pos = 3'd1;
         PAT_POS2: dec.pos = 3'd2;
         PAT_POS3: dec.pos = 3'd3;
         PAT_POS4: dec.pos = 3'd4;
         PAT_POS5: dec.pos = 3'd5;
         PAT_POS6: dec.pos = 3'd6;
         default:  dec.known = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

>>> sv/lsps_back.sv
// Back end: PID state update, gain multiplies, clamp and duty saturation.
module lsps_back import lsps_pkg::*; #(
   parameter int SUM_WIDTH = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DUTY_W-1:0] rsp_left_duty,
   output logic [DUTY_W-1:0] rsp_right_duty,
   output logic [POS_W-1:0]  rsp_line_position,
   output logic signed [DRIVE_W-1:0] rsp_steer_drive
);

   localparam int PI_W  = GAIN_W + 1 + SUM_WIDTH;
   localparam int TOT_W = SUM_WIDTH + 15;
   localparam int DS_W  = DUTY_W + 2;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   // controller state
   logic [POS_W-1:0]            held_ff;
   logic signed [ERR_W-1:0]     last_err_ff;
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic signed [DRIVE_W-1:0]   drive_ff;

   // stage registers
   logic                        v1_ff, v2_ff, v3_ff;
   logic                        chg1_ff, chg2_ff;
   logic [POS_W-1:0]            pos1_ff, pos2_ff, pos3_ff;
   logic signed [ERR_W-1:0]     err1_ff;
   logic signed [DER_W-1:0]     der1_ff;
   logic signed [SUM_WIDTH-1:0] sum1_ff;
   logic signed [ERR_W+GAIN_W:0] pp_ff;
   logic signed [DER_W+GAIN_W:0] pd_ff;
   logic signed [PI_W-1:0]      pi_ff;
   logic signed [DRIVE_W-1:0]   drv3_ff;

   logic                        advance;
   logic                        chg;
   logic signed [ERR_W-1:0]     err;
   logic signed [DER_W-1:0]     der;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   logic [POS_W-1:0]            pos_after;
   logic signed [ERR_W+GAIN_W:0] pp;
   logic signed [DER_W+GAIN_W:0] pd;
   logic signed [PI_W-1:0]      pi;
   logic signed [TOT_W-1:0]     total;
   logic signed [TOT_W-1:0]     lim_w;
   logic signed [TOT_W-1:0]     clamped;
   logic signed [DRIVE_W-1:0]   drv3;
   logic signed [DS_W-1:0]      base_w;
   logic signed [DS_W-1:0]      left_w;
   logic signed [DS_W-1:0]      right_w;
   logic [DUTY_W-1:0]           left_sat;
   logic [DUTY_W-1:0]           right_sat;

   // whole pipeline moves unless the output word is stalled
   assign advance = !rsp_valid || rsp_ready;
   assign q_pop   = advance && q_valid;

   // stage 1: position change, error, derivative, integral
   always_comb begin
      chg = q_item.known && (q_item.pos != held_ff);
      err = $signed({1'b0, cfg.target}) - $signed({1'b0, q_item.pos});
      der = $signed({err[ERR_W-1], err}) - $signed({last_err_ff[ERR_W-1], last_err_ff});
      sum_wide = $signed({sum_ff[SUM_WIDTH-1], sum_ff})
               + $signed({{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err});
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
      pos_after = chg ? q_item.pos : held_ff;
   end

   // stage 2: gain products
   always_comb begin
      pp = $signed({{(ERR_W+1){1'b0}}, cfg.gain_p})
         * $signed({{(GAIN_W+1){err1_ff[ERR_W-1]}}, err1_ff});
      pd = $signed({{(DER_W+1){1'b0}}, cfg.gain_d})
         * $signed({{(GAIN_W+1){der1_ff[DER_W-1]}}, der1_ff});
      pi = $signed({{(SUM_WIDTH+1){1'b0}}, cfg.gain_i})
         * $signed({{(GAIN_W+1){sum1_ff[SUM_WIDTH-1]}}, sum1_ff});
   end

   // stage 3: sum, clamp, edge override; unchanged words take the held drive
   always_comb begin
      total = $signed({{(TOT_W-ERR_W-GAIN_W-1){pp_ff[ERR_W+GAIN_W]}}, pp_ff})
            + $signed({{(TOT_W-DER_W-GAIN_W-1){pd_ff[DER_W+GAIN_W]}}, pd_ff})
            + $signed({{(TOT_W-PI_W){pi_ff[PI_W-1]}}, pi_ff});
      lim_w = $signed({{(TOT_W-LIM_W){1'b0}}, cfg.drive_limit});
      if (total > lim_w) begin
         clamped = lim_w;
      end else if (total < -lim_w) begin
         clamped = -lim_w;
      end else begin
         clamped = total;
      end
      if (pos2_ff == POS_LEFT_EDGE) begin
         clamped = lim_w;
      end else if (pos2_ff == POS_RIGHT_EDGE) begin
         clamped = -lim_w;
      end
      drv3 = chg2_ff ? clamped[DRIVE_W-1:0] : drive_ff;
   end

   // stage 4: duty saturation
   always_comb begin
      base_w  = $signed({2'b00, cfg.base_duty});
      left_w  = base_w - $signed({{(DS_W-DRIVE_W){drv3_ff[DRIVE_W-1]}}, drv3_ff});
      right_w = base_w + $signed({{(DS_W-DRIVE_W){drv3_ff[DRIVE_W-1]}}, drv3_ff});
      if (left_w[DS_W-1]) begin
         left_sat = '0;
      end else if (left_w[DUTY_W]) begin
         left_sat = '1;
      end else begin
         left_sat = left_w[DUTY_W-1:0];
      end
      if (right_w[DS_W-1]) begin
         right_sat = '0;
      end else if (right_w[DUTY_W]) begin
         right_sat = '1;
      end else begin
         right_sat = right_w[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= POS_CENTER;
         last_err_ff <= '0;
         sum_ff      <= '0;
         drive_ff    <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (advance) begin
         if (q_valid && chg) begin
            held_ff     <= q_item.pos;
            last_err_ff <= err;
            sum_ff      <= sum_sat;
         end
         if (v2_ff && chg2_ff) begin
            drive_ff <= clamped[DRIVE_W-1:0];
         end
         v1_ff     <= q_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         rsp_valid <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chg1_ff <= chg;
         pos1_ff <= pos_after;
         err1_ff <= err;
         der1_ff <= der;
         sum1_ff <= sum_sat;

         chg2_ff <= v1_ff && chg1_ff;
         pos2_ff <= pos1_ff;
         pp_ff   <= pp;
         pd_ff   <= pd;
         pi_ff   <= pi;

         pos3_ff <= pos2_ff;
         drv3_ff <= drv3;

         rsp_left_duty     <= left_sat;
         rsp_right_duty    <= right_sat;
         rsp_line_position <= pos3_ff;
         rsp_steer_drive   <= drv3_ff;
      end
   end

endmodule

>>> sv/line_sensor_pid_steering.sv
// Line sensor PID steering: top level with register file, front end and back end.
//
// Input channel req_*: one raw sensor byte per word, valid/ready handshake.
// Result channel rsp_*: one word per input word, in order: left and right
// duty (base minus/plus drive, saturated to 16 bits), held line position and
// the signed steering drive.
// Register port csr_*: a write with csr_write_en high stores csr_wdata into
// the register named by csr_index; unknown indexes are dropped. Write only
// while no word is in flight.
// Throughput: one word per cycle while rsp_ready does not stall the back end.
// An accepted word is registered in the two-entry decode queue and then in
// the stages of state update, gain multiply, sum and clamp, and duty register.
// A stalled rsp_ready freezes the back end; the queue keeps taking words
// until its two entries are full, then req_ready drops.
// Reset (synchronous, active high) restores all registers to defaults,
// centers the held position and clears error, integral and drive.
module line_sensor_pid_steering import lsps_pkg::*; #(
   parameter int SUM_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PAT_W-1:0]      req_sensor_pattern,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DUTY_W-1:0]     rsp_left_duty,
   output logic [DUTY_W-1:0]     rsp_right_duty,
   output logic [POS_W-1:0]      rsp_line_position,
   output logic signed [DRIVE_W-1:0] rsp_steer_drive,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN_P:      cfg_in.gain_p      = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:      cfg_in.gain_d      = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:      cfg_in.gain_i      = csr_wdata[GAIN_W-1:0];
            CSR_TARGET:      cfg_in.target      = csr_wdata[POS_W-1:0];
            CSR_BASE_DUTY:   cfg_in.base_duty   = csr_wdata[DUTY_W-1:0];
            CSR_DRIVE_LIMIT: cfg_in.drive_limit = csr_wdata[LIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p      <= GAIN_P_RST;
         cfg_ff.gain_d      <= GAIN_D_RST;
         cfg_ff.gain_i      <= GAIN_I_RST;
         cfg_ff.target      <= TARGET_RST;
         cfg_ff.base_duty   <= BASE_DUTY_RST;
         cfg_ff.drive_limit <= DRIVE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsps_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sensor_pattern (req_sensor_pattern),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   lsps_back #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_line_position (rsp_line_position),
      .rsp_steer_drive   (rsp_steer_drive)
   );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the line sensor PID steering block.
module testbench;
   import lsps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     SUM_WIDTH    = 24;
   localparam longint SUM_MAX      = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
   localparam longint SUM_MIN      = -SUM_MAX - 1;
   localparam int     DRAIN_CYCLES = 8;
   localparam int     MAX_CYCLES   = 400000;
   localparam int     MAX_GAP      = 8;
   localparam int     PHASES       = 12;
   localparam int     PHASE_WORDS  = 100;

   // indexes past the end of the register list; writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [PAT_W-1:0] LINE_PATTERNS [7] =
      '{PAT_POS0, PAT_POS1, PAT_POS2, PAT_POS3, PAT_POS4, PAT_POS5, PAT_POS6};

   typedef struct {
      logic [DUTY_W-1:0]         left_duty;
      logic [DUTY_W-1:0]         right_duty;
      logic [POS_W-1:0]          line_pos;
      logic signed [DRIVE_W-1:0] steer;
   } steer_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [PAT_W-1:0]            req_sensor_pattern = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [DUTY_W-1:0]           rsp_left_duty;
   logic [DUTY_W-1:0]           rsp_right_duty;
   logic [POS_W-1:0]            rsp_line_position;
   logic signed [DRIVE_W-1:0]   rsp_steer_drive;
   logic                        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   // predictor state and register copy
   cfg_type          regs;
   logic [POS_W-1:0] held_pos;
   int               prev_err;
   longint           err_sum;
   longint           drive_now;

   steer_word_type pending_steer[$];
   bit          sender_idles;
   bit          receiver_idles;
   int          rsp_hold;
   int          cycle_count;
   int          fail_count;

   line_sensor_pid_steering #(.SUM_WIDTH(SUM_WIDTH)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sensor_pattern (req_sensor_pattern),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_line_position  (rsp_line_position),
      .rsp_steer_drive    (rsp_steer_drive),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("FAIL line_sensor_pid_steering");
         $finish;
      end
   end

   function automatic logic [DUTY_W-1:0] clip_duty(input longint v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return v[DUTY_W-1:0];
   endfunction

   function automatic void reset_predictor();
      regs.gain_p      = GAIN_P_RST;
      regs.gain_d      = GAIN_D_RST;
      regs.gain_i      = GAIN_I_RST;
      regs.target      = TARGET_RST;
      regs.base_duty   = BASE_DUTY_RST;
      regs.drive_limit = DRIVE_LIMIT_RST;
      held_pos  = POS_CENTER;
      prev_err  = 0;
      err_sum   = 0;
      drive_now = 0;
   endfunction

   function automatic steer_word_type predict_steering(input logic [PAT_W-1:0] pattern);
      logic [POS_W-1:0] pos;
      int               err;
      int               der;
      longint           sum;
      longint           drv;
      longint           lim;
      steer_word_type   w;
      pos = held_pos;
      for (int i = 0; i < 7; i++)
         if (pattern == LINE_PATTERNS[i]) pos = POS_W'(i);
      if (pos != held_pos) begin
         lim = longint'(regs.drive_limit);
         err = int'(regs.target) - int'(pos);
         der = err - prev_err;
         sum = err_sum + err;
         if (sum > SUM_MAX) sum = SUM_MAX;
         if (sum < SUM_MIN) sum = SUM_MIN;
         err_sum = sum;
         drv = longint'(regs.gain_p) * err + longint'(regs.gain_d) * der
               + longint'(regs.gain_i) * sum;
         if (drv > lim) drv = lim;
         if (drv < -lim) drv = -lim;
         // sharp turns at the two outer sensors
         if (pos == POS_LEFT_EDGE) drv = lim;
         if (pos == POS_RIGHT_EDGE) drv = -lim;
         drive_now = drv;
         prev_err  = err;
         held_pos  = pos;
      end
      w.left_duty  = clip_duty(longint'(regs.base_duty) - drive_now);
      w.right_duty = clip_duty(longint'(regs.base_duty) + drive_now);
      w.line_pos   = held_pos;
      w.steer      = drive_now[DRIVE_W-1:0];
      return w;
   endfunction

   // result side: stall after each accepted word by a drawn count
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         rsp_hold = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      steer_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_steer.size() == 0) begin
            $error("result word with no expectation waiting");
            fail_count++;
         end else begin
            w = pending_steer.pop_front();
            if (rsp_left_duty !== w.left_duty) begin
               $error("left_duty expected %0d got %0d", w.left_duty, rsp_left_duty);
               fail_count++;
            end
            if (rsp_right_duty !== w.right_duty) begin
               $error("right_duty expected %0d got %0d", w.right_duty, rsp_right_duty);
               fail_count++;
            end
            if (rsp_line_position !== w.line_pos) begin
               $error("line_position expected %0d got %0d", w.line_pos, rsp_line_position);
               fail_count++;
            end
            if (rsp_steer_drive !== w.steer) begin
               $error("steer_drive expected %0d got %0d", w.steer, rsp_steer_drive);
               fail_count++;
            end
         end
      end
   end

   task automatic send_pattern(input logic [PAT_W-1:0] pattern);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sensor_pattern <= pattern;
      do @(posedge clock); while (!req_ready);
      pending_steer.push_back(predict_steering(pattern));
   endtask

   // drop valid and hold until every expected word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_steer.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_GAIN_P:      regs.gain_p      = data[GAIN_W-1:0];
         CSR_GAIN_D:      regs.gain_d      = data[GAIN_W-1:0];
         CSR_GAIN_I:      regs.gain_i      = data[GAIN_W-1:0];
         CSR_TARGET:      regs.target      = data[POS_W-1:0];
         CSR_BASE_DUTY:   regs.base_duty   = data[DUTY_W-1:0];
         CSR_DRIVE_LIMIT: regs.drive_limit = data[LIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [CSR_DATA_W-1:0] gp, gd, gi, tgt, base, lim);
      wait_drained();
      write_csr(CSR_GAIN_P, gp);
      write_csr(CSR_GAIN_D, gd);
      write_csr(CSR_GAIN_I, gi);
      write_csr(CSR_TARGET, tgt);
      write_csr(CSR_BASE_DUTY, base);
      write_csr(CSR_DRIVE_LIMIT, lim);
      write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_field(input int unsigned top);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return CSR_DATA_W'(top);
         2: return 16'($urandom);  // upper bits beyond the register get dropped
         default: return CSR_DATA_W'($urandom_range(0, top));
      endcase
   endfunction

   function automatic logic [PAT_W-1:0] pick_pattern();
      if ($urandom_range(0, 3) != 0) return LINE_PATTERNS[$urandom_range(0, 6)];
      return PAT_W'($urandom_range(0, 255));
   endfunction

   task automatic test_default_sweep();
      logic [PAT_W-1:0] seq [12];
      seq = '{PAT_POS3, PAT_POS0, PAT_POS1, PAT_POS2, PAT_POS3, PAT_POS4, PAT_POS5,
              PAT_POS6, 8'h00, 8'hFF, PAT_POS6, PAT_POS0};
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      foreach (seq[i]) send_pattern(seq[i]);
   endtask

   task automatic test_register_extremes();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      // everything at the top: the duty that the drive raises pins at full scale, target past the right edge
      set_registers(16'd4095, 16'd4095, 16'd4095, 16'd7, 16'd65535, 16'd8191);
      send_pattern(PAT_POS0);
      send_pattern(PAT_POS6);
      send_pattern(PAT_POS3);
      send_pattern(PAT_POS4);
      // everything at zero
      set_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_pattern(PAT_POS1);
      send_pattern(PAT_POS2);
      send_pattern(8'h55);
      // zero base with a full drive: left floors at zero
      set_registers(16'd4095, 16'd0, 16'd4095, 16'd7, 16'd0, 16'd8191);
      send_pattern(PAT_POS5);
      send_pattern(PAT_POS4);
      send_pattern(PAT_POS2);
      send_pattern(8'hAA);
   endtask

   task automatic test_drain_pause();
      sender_idles   = 1'b0;
      receiver_idles = 1'b1;
      repeat (20) send_pattern(pick_pattern());
      wait_drained();
      repeat (20) send_pattern(pick_pattern());
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < PHASES; p++) begin
         set_registers(pick_field(4095), pick_field(4095), pick_field(4095),
                       pick_field(7), pick_field(65535), pick_field(8191));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // switch idling on and off in stretches
            if (n % 25 == 0) begin
               sender_idles   = $urandom_range(0, 3) != 0;
               receiver_idles = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 60) == 0) wait_drained();
            send_pattern(pick_pattern());
         end
      end
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_sweep();
      test_register_extremes();
      test_drain_pause();
      test_random_phases();
      wait_drained();
      if (fail_count == 0) begin
         $display("PASS line_sensor_pid_steering");
      end else begin
         $display("FAIL line_sensor_pid_steering");
      end
      $finish;
   end

endmodule
